// File: rtl/i2cram_pkg.sv
package i2cram_pkg;

    // Tick counter width; a half period above its range saturates
    localparam int TICK_COUNTER_BITS = 16;

    localparam int HALF_BITS = 16;
    localparam int ADDR_BITS = 7;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_DEVICE_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_PERIOD    = 1'b1;

    localparam logic [ADDR_BITS-1:0] DEV_ADDR_RESET = 7'd36;
    localparam logic [HALF_BITS-1:0] HALF_RESET     = 16'd100;

    // Bus sequencer phases
    localparam logic [4:0] PH_IDLE    = 5'd0;
    localparam logic [4:0] PH_START_A = 5'd1;
    localparam logic [4:0] PH_START_B = 5'd2;
    localparam logic [4:0] PH_TX_LO   = 5'd3;
    localparam logic [4:0] PH_TX_HI   = 5'd4;
    localparam logic [4:0] PH_ACK_LO  = 5'd5;
    localparam logic [4:0] PH_ACK_HI  = 5'd6;
    localparam logic [4:0] PH_RS_A    = 5'd7;
    localparam logic [4:0] PH_RS_B    = 5'd8;
    localparam logic [4:0] PH_RS_C    = 5'd9;
    localparam logic [4:0] PH_RX_LO   = 5'd10;
    localparam logic [4:0] PH_RX_HI   = 5'd11;
    localparam logic [4:0] PH_NACK_LO = 5'd12;
    localparam logic [4:0] PH_NACK_HI = 5'd13;
    localparam logic [4:0] PH_STOP_A  = 5'd14;
    localparam logic [4:0] PH_STOP_B  = 5'd15;
    localparam logic [4:0] PH_FINISH  = 5'd16;

    // Byte stages of a transaction
    localparam logic [1:0] STG_ADDR_W = 2'd0;
    localparam logic [1:0] STG_REG    = 2'd1;
    localparam logic [1:0] STG_DATA   = 2'd2;
    localparam logic [1:0] STG_ADDR_R = 2'd3;

    typedef struct packed {
        logic       request;
        logic       mode;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic       sda_in;
    } t_in_word;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic       ack_ok;
        logic [7:0] read_data;
    } t_out_word;

    typedef struct packed {
        logic [ADDR_BITS-1:0] device_address;
        logic [HALF_BITS-1:0] half_period_ticks;
    } t_cfg;

    // Queue head as seen by the sequencer
    typedef struct packed {
        logic     valid;
        t_in_word word;
    } t_q_head;

endpackage

// File: rtl/i2cram_if.sv
interface i2cram_in_if;
    logic       valid;
    logic       ready;
    logic       request;
    logic       mode;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       sda_in;

    modport source (output valid, request, mode, reg_addr, write_data, sda_in, input ready);
    modport sink (input valid, request, mode, reg_addr, write_data, sda_in, output ready);
endinterface

interface i2cram_out_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic       ack_ok;
    logic [7:0] read_data;

    modport source (output valid, scl_level, sda_level, busy_res, done_res, ack_ok, read_data,
                    input ready);
    modport sink (input valid, scl_level, sda_level, busy_res, done_res, ack_ok, read_data,
                  output ready);
endinterface

interface i2cram_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/i2cram_front.sv
module i2cram_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  i2cram_pkg::t_in_word i_word,
    input  logic                 i_pop,
    output i2cram_pkg::t_q_head  o_head
);
    import i2cram_pkg::*;

    t_in_word   r_mem [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_count, n_count;
    logic       push;
    logic       pop;

    assign o_ready = (r_count != 2'd2);
    assign push    = i_valid & o_ready;
    assign pop     = i_pop & (r_count != 2'd0);

    always_comb begin
        n_wptr  = push ? ~r_wptr : r_wptr;
        n_rptr  = pop ? ~r_rptr : r_rptr;
        n_count = r_count + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_word;
        end
    end

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.word  = r_mem[r_rptr];

endmodule

// File: rtl/i2cram_seq.sv
module i2cram_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  i2cram_pkg::t_cfg      i_cfg,
    input  i2cram_pkg::t_q_head   i_head,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output i2cram_pkg::t_out_word o_word
);
    import i2cram_pkg::*;

    localparam int TCB = TICK_COUNTER_BITS;
    localparam logic [31:0] CMAX = 32'((64'd1 << TCB) - 64'd1);

    logic [4:0]     r_phase, n_phase, e_phase;
    logic [2:0]     r_bit, n_bit, e_bit;
    logic [7:0]     r_shift, n_shift, e_shift;
    logic [TCB-1:0] r_tick, n_tick, e_tick;
    logic           r_mode, n_mode, e_mode;
    logic [7:0]     r_reg, n_reg, e_reg;
    logic [7:0]     r_wd, n_wd, e_wd;
    logic           r_ok, n_ok, e_ok;
    logic [1:0]     r_stage, n_stage, e_stage;

    logic           r_valid;
    t_out_word      r_out, n_out;
    logic           take;
    logic [31:0]    seg_len;
    logic [32:0]    tick_p1;
    logic           seg_end;
    t_in_word       w;
    logic           tx_bit;

    assign w    = i_head.word;
    assign take = i_head.valid & (~r_valid | i_ready);
    assign o_pop = take;

    // Segment length: zero counts as one, saturate at the counter range
    always_comb begin
        seg_len = 32'(i_cfg.half_period_ticks);
        if (seg_len == 32'd0) begin
            seg_len = 32'd1;
        end
        if (seg_len > CMAX) begin
            seg_len = CMAX;
        end
    end

    always_comb begin
        e_phase = r_phase;
        e_bit   = r_bit;
        e_shift = r_shift;
        e_tick  = r_tick;
        e_mode  = r_mode;
        e_reg   = r_reg;
        e_wd    = r_wd;
        e_ok    = r_ok;
        e_stage = r_stage;

        // Latch a request from idle; the first start segment shows this tick
        if (r_phase == PH_IDLE && w.request) begin
            e_mode  = w.mode;
            e_reg   = w.reg_addr;
            e_wd    = w.write_data;
            e_ok    = 1'b1;
            e_stage = STG_ADDR_W;
            e_bit   = 3'd0;
            e_shift = 8'd0;
            e_tick  = '0;
            e_phase = PH_START_A;
        end

        tx_bit  = e_shift[e_bit];
        tick_p1 = 33'(e_tick) + 33'd1;
        seg_end = (tick_p1 >= {1'b0, seg_len});

        n_out = '{scl_level: 1'b1, sda_level: 1'b1, busy_res: 1'b1, done_res: 1'b0,
                  ack_ok: 1'b0, read_data: 8'd0};
        unique case (e_phase) inside
            PH_IDLE:    n_out.busy_res = 1'b0;
            PH_START_B: n_out.sda_level = 1'b0;
            PH_TX_LO: begin
                n_out.scl_level = 1'b0;
                n_out.sda_level = tx_bit;
            end
            PH_TX_HI:   n_out.sda_level = tx_bit;
            PH_ACK_LO, PH_RS_A, PH_RX_LO, PH_NACK_LO: n_out.scl_level = 1'b0;
            PH_RS_C:    n_out.sda_level = 1'b0;
            PH_STOP_A: begin
                n_out.scl_level = 1'b0;
                n_out.sda_level = 1'b0;
            end
            PH_STOP_B:  n_out.sda_level = 1'b0;
            PH_FINISH: begin
                n_out.busy_res  = 1'b0;
                n_out.done_res  = 1'b1;
                n_out.ack_ok    = e_ok;
                n_out.read_data = (e_ok && !e_mode) ? e_shift : 8'd0;
            end
            default: ;
        endcase

        n_phase = e_phase;
        n_bit   = e_bit;
        n_shift = e_shift;
        n_tick  = e_tick;
        n_mode  = e_mode;
        n_reg   = e_reg;
        n_wd    = e_wd;
        n_ok    = e_ok;
        n_stage = e_stage;

        if (e_phase >= PH_FINISH) begin
            n_phase = PH_IDLE;
            n_tick  = '0;
        end else if (e_phase != PH_IDLE) begin
            if (!seg_end) begin
                n_tick = tick_p1[TCB-1:0];
            end else begin
                n_tick = '0;
                unique case (e_phase)
                    PH_START_A: n_phase = PH_START_B;
                    PH_START_B: begin
                        n_stage = STG_ADDR_W;
                        n_shift = {i_cfg.device_address, 1'b0};
                        n_bit   = 3'd7;
                        n_phase = PH_TX_LO;
                    end
                    PH_TX_LO: n_phase = PH_TX_HI;
                    PH_TX_HI: begin
                        if (e_bit == 3'd0) begin
                            n_phase = PH_ACK_LO;
                        end else begin
                            n_bit   = e_bit - 3'd1;
                            n_phase = PH_TX_LO;
                        end
                    end
                    PH_ACK_LO: n_phase = PH_ACK_HI;
                    PH_ACK_HI: begin
                        if (w.sda_in) begin
                            n_ok    = 1'b0;
                            n_phase = PH_STOP_A;
                        end else if (e_stage == STG_ADDR_W) begin
                            n_stage = STG_REG;
                            n_shift = e_reg;
                            n_bit   = 3'd7;
                            n_phase = PH_TX_LO;
                        end else if (e_stage == STG_REG) begin
                            if (e_mode) begin
                                n_stage = STG_DATA;
                                n_shift = e_wd;
                                n_bit   = 3'd7;
                                n_phase = PH_TX_LO;
                            end else begin
                                n_phase = PH_RS_A;
                            end
                        end else if (e_stage == STG_ADDR_R) begin
                            n_shift = 8'd0;
                            n_bit   = 3'd7;
                            n_phase = PH_RX_LO;
                        end else begin
                            n_phase = PH_STOP_A;
                        end
                    end
                    PH_RS_A: n_phase = PH_RS_B;
                    PH_RS_B: n_phase = PH_RS_C;
                    PH_RS_C: begin
                        n_stage = STG_ADDR_R;
                        n_shift = {i_cfg.device_address, 1'b1};
                        n_bit   = 3'd7;
                        n_phase = PH_TX_LO;
                    end
                    PH_RX_LO: n_phase = PH_RX_HI;
                    PH_RX_HI: begin
                        n_shift = {e_shift[6:0], w.sda_in};
                        if (e_bit == 3'd0) begin
                            n_phase = PH_NACK_LO;
                        end else begin
                            n_bit   = e_bit - 3'd1;
                            n_phase = PH_RX_LO;
                        end
                    end
                    PH_NACK_LO: n_phase = PH_NACK_HI;
                    PH_NACK_HI: n_phase = PH_STOP_A;
                    PH_STOP_A:  n_phase = PH_STOP_B;
                    PH_STOP_B:  n_phase = PH_FINISH;
                    default:    n_phase = PH_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_bit   <= 3'd0;
            r_shift <= 8'd0;
            r_tick  <= '0;
            r_mode  <= 1'b0;
            r_reg   <= 8'd0;
            r_wd    <= 8'd0;
            r_ok    <= 1'b0;
            r_stage <= STG_ADDR_W;
            r_valid <= 1'b0;
        end else begin
            if (take) begin
                r_phase <= n_phase;
                r_bit   <= n_bit;
                r_shift <= n_shift;
                r_tick  <= n_tick;
                r_mode  <= n_mode;
                r_reg   <= n_reg;
                r_wd    <= n_wd;
                r_ok    <= n_ok;
                r_stage <= n_stage;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_out;

endmodule

// File: rtl/i2c_register_access_master.sv
// Path: an accepted word is written into the input queue, then the sequencer registers its result word.
// Throughput: one word per cycle sustained; the two-entry input queue and the result register
// let either side stall while the other keeps moving.
// The sequencer takes one tick word per cycle, so the rate is set by that single update step.
// Reset: synchronous, active low; queue empty, sequencer idle, device address 36, half period 100.
module i2c_register_access_master (
    input  logic i_clk,
    input  logic i_rst_n,
    i2cram_in_if.sink    i_in,
    i2cram_out_if.source o_out,
    i2cram_cfg_if.sink   i_cfg
);
    import i2cram_pkg::*;

    // Configuration registers: device address and half period, always ready
    t_cfg      r_cfg;
    t_in_word  in_word;
    t_q_head   q_head;
    logic      q_pop;
    t_out_word out_word;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address    <= DEV_ADDR_RESET;
            r_cfg.half_period_ticks <= HALF_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_DEVICE_ADDRESS: r_cfg.device_address <= i_cfg.data[ADDR_BITS-1:0];
                CFG_HALF_PERIOD:    r_cfg.half_period_ticks <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Pack the incoming tick word
    assign in_word.request    = i_in.request;
    assign in_word.mode       = i_in.mode;
    assign in_word.reg_addr   = i_in.reg_addr;
    assign in_word.write_data = i_in.write_data;
    assign in_word.sda_in     = i_in.sda_in;

    // Front: hold accepted words in a short queue
    i2cram_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_word  (in_word),
        .i_pop   (q_pop),
        .o_head  (q_head)
    );

    // Back: advance the bus sequencer one tick per word, register the result
    i2cram_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_head  (q_head),
        .o_pop   (q_pop),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_word  (out_word)
    );

    assign o_out.scl_level = out_word.scl_level;
    assign o_out.sda_level = out_word.sda_level;
    assign o_out.busy_res  = out_word.busy_res;
    assign o_out.done_res  = out_word.done_res;
    assign o_out.ack_ok    = out_word.ack_ok;
    assign o_out.read_data = out_word.read_data;

endmodule
